/* design/lid_pkg.sv */
`default_nettype none

package lid_pkg;

    localparam int unsigned THRESHOLD_W = 3;
    localparam int unsigned HOLDOFF_W   = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned TOTAL_W     = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TIME     = 1'd1;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 3'd2;
    localparam logic [HOLDOFF_W-1:0]   HOLDOFF_RESET   = 16'd1000;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX       = 8'd255;

    typedef struct packed {
        logic              left_bit;
        logic              right_bit;
        logic [TIME_W-1:0] now_ms;
    } t_lid_in;

    typedef struct packed {
        logic               left_event;
        logic               right_event;
        logic [TOTAL_W-1:0] left_total;
        logic [TOTAL_W-1:0] right_total;
    } t_lid_out;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] detect_threshold;
        logic [HOLDOFF_W-1:0]   holdoff_time;
    } t_lid_cfg;

endpackage

`default_nettype wire

/* design/lid_side.sv */
`default_nettype none

module lid_side
    import lid_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_bit,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire t_lid_cfg           i_cfg,
    output logic                    o_event,
    output logic [TOTAL_W-1:0]      o_total
);

    localparam int unsigned ONES_W = $clog2(WINDOW + 1);
    localparam int unsigned CMP_W  = (ONES_W > THRESHOLD_W) ? ONES_W : THRESHOLD_W;

    logic [WINDOW-1:0]  r_window, n_window;
    logic [ONES_W-1:0]  r_ones, n_ones;
    logic               r_ready, n_ready;
    logic [TIME_W-1:0]  r_mark, n_mark;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic               pushed;
    logic               oldest;
    logic [WINDOW-1:0]  shifted;
    logic [ONES_W-1:0]  ones_sh;
    logic [TIME_W-1:0]  elapsed;
    logic               hit;

    always_comb begin
        oldest  = r_window[WINDOW-1];
        pushed  = r_ready & i_bit;
        shifted = (r_window << 1) | WINDOW'(pushed);
        ones_sh = r_ones + ONES_W'(pushed) - ONES_W'(oldest);
        elapsed = i_now_ms - r_mark;
        hit     = (CMP_W'(ones_sh) == CMP_W'(i_cfg.detect_threshold));

        n_window = shifted;
        n_ones   = ones_sh;
        n_ready  = r_ready | (elapsed > TIME_W'(i_cfg.holdoff_time));
        n_mark   = r_mark;
        n_total  = r_total;
        if (hit) begin
            n_window = '0;
            n_ones   = '0;
            n_ready  = 1'b0;
            n_mark   = i_now_ms;
            if (r_total != TOTAL_MAX) begin
                n_total = r_total + TOTAL_W'(1);
            end
        end
        o_event = hit;
        o_total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_ones   <= '0;
            r_ready  <= 1'b1;
            r_mark   <= '0;
            r_total  <= '0;
        end else if (i_en) begin
            r_window <= n_window;
            r_ones   <= n_ones;
            r_ready  <= n_ready;
            r_mark   <= n_mark;
            r_total  <= n_total;
        end
    end

endmodule

`default_nettype wire

/* design/line_intersection_detector_core.sv */
// each result is registered and presented in the cycle after its input transfer
// throughput: one item per cycle while i_ready stays high; the output register refills on the cycle it is taken
// each side does one window shift, one ones count update and one 32-bit time compare per item
// reset (synchronous, active low): windows and counts cleared, totals zero, both sides ready,
// threshold 2, hold-off 1000 ms, output register empty
`default_nettype none

module line_intersection_detector_core
    import lid_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_lid_in               i_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_lid_out                   o_out
);

    t_lid_cfg           r_cfg;
    t_lid_out           r_out, n_out;
    logic               r_out_valid;
    logic               accept;
    logic               left_event;
    logic               right_event;
    logic [TOTAL_W-1:0] left_total;
    logic [TOTAL_W-1:0] right_total;

    always_comb begin
        o_ready = !r_out_valid || i_ready;
        accept  = i_valid && o_ready;
        o_valid = r_out_valid;
        o_out   = r_out;

        n_out.left_event  = left_event;
        n_out.right_event = right_event;
        n_out.left_total  = left_total;
        n_out.right_total = right_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_threshold <= THRESHOLD_RESET;
            r_cfg.holdoff_time     <= HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DETECT_THRESHOLD: begin
                    r_cfg.detect_threshold <= i_cfg_data[THRESHOLD_W-1:0];
                end
                REG_HOLDOFF_TIME: begin
                    r_cfg.holdoff_time <= i_cfg_data[HOLDOFF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lid_side #(
        .WINDOW (WINDOW)
    ) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_bit    (i_in.left_bit),
        .i_now_ms (i_in.now_ms),
        .i_cfg    (r_cfg),
        .o_event  (left_event),
        .o_total  (left_total)
    );

    lid_side #(
        .WINDOW (WINDOW)
    ) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_bit    (i_in.right_bit),
        .i_now_ms (i_in.now_ms),
        .i_cfg    (r_cfg),
        .o_event  (right_event),
        .o_total  (right_total)
    );

    // output register, refilled on the same cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
